// ----- rtl/u2k_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2k_pkg: shared types and constants for the UTF-8 to keystroke block
// Event codes, key classes, host entry methods and the controller/datapath
// command and status words.
// ----------------------------------------------------------------------------
package u2k_pkg;

	localparam int CP_W       = 21;
	localparam int BCD_DIGITS = 7;
	localparam int CONV_STEPS = CP_W;
	localparam int CNT_W      = $clog2(CONV_STEPS + 1);

	typedef logic [1:0] action_t;
	localparam action_t ACT_PRESS   = 2'd0;
	localparam action_t ACT_RELEASE = 2'd1;
	localparam action_t ACT_TYPE    = 2'd2;
	localparam action_t ACT_REJECT  = 2'd3;

	typedef logic [2:0] class_t;
	localparam class_t CLS_CHAR   = 3'd0;
	localparam class_t CLS_NUMPAD = 3'd1;
	localparam class_t CLS_CTRL   = 3'd2;
	localparam class_t CLS_SHIFT  = 3'd3;
	localparam class_t CLS_ALT    = 3'd4;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_WIN = 2'd0;
	localparam mode_t MODE_LIN = 2'd1;
	localparam mode_t MODE_MAC = 2'd2;
	localparam mode_t MODE_UNK = 2'd3;

	// Outcome of decoding one byte
	typedef logic [1:0] res_t;
	localparam res_t RES_NONE   = 2'd0;
	localparam res_t RES_REJECT = 2'd1;
	localparam res_t RES_TYPE   = 2'd2;
	localparam res_t RES_KEYS   = 2'd3;

	// Source of key_value for an event
	typedef logic [2:0] vkind_t;
	localparam vkind_t VK_ZERO  = 3'd0;
	localparam vkind_t VK_CP    = 3'd1;
	localparam vkind_t VK_U     = 3'd2;
	localparam vkind_t VK_SPACE = 3'd3;
	localparam vkind_t VK_HEX   = 3'd4;
	localparam vkind_t VK_NUM   = 3'd5;
	localparam vkind_t VK_NUM0  = 3'd6;

	localparam logic [7:0] NUMPAD_ZERO = 8'h62;
	localparam logic [7:0] NUMPAD_ONE  = 8'h59;
	localparam logic [7:0] KEY_U       = 8'h75;
	localparam logic [7:0] KEY_SPACE   = 8'h20;

	localparam logic [CP_W-1:0] VS_LO  = 21'h0FE00;
	localparam logic [CP_W-1:0] VS_HI  = 21'h0FE0F;
	localparam logic [CP_W-1:0] VSS_LO = 21'hE0100;
	localparam logic [CP_W-1:0] VSS_HI = 21'hE01EF;

	typedef struct packed {
		logic    load_in;
		logic    decode;
		logic    conv_step;
		logic    emit;
		action_t ev_action;
		class_t  ev_class;
		vkind_t  ev_vkind;
		logic [2:0] ev_dig;
		logic    ev_end;
	} u2k_cmd_t;

	typedef struct packed {
		res_t    res;
		mode_t   mode;
		logic    big;
		logic [2:0] ndig;
		logic    out_free;
	} u2k_status_t;

endpackage

// ----- rtl/utf8_to_unicode_keystrokes.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_unicode_keystrokes: UTF-8 text to host keystroke events
// Decodes UTF-8 one byte per word and turns each code point into a type
// event or a series of key events for the selected host entry method.
//
//   channel  direction  handshake             word
//   in       sink       in_valid / in_ready   byte_value, last_byte
//   out      source     out_valid / out_ready action, key_class, key_value,
//                                             run_end
//   cfg      sink       cfg_valid / cfg_ready platform_mode
//
// Sequence: a byte is registered when taken, then decoded. A byte that
//   gives no event frees the input after decode; ASCII and reject words
//   free it once their word is emitted. A Windows code point goes through
//   the bit-serial decimal converter, then every event goes through the
//   output register: up to 20 events (Linux), 18 (Windows), 14 (macOS).
// Reset: arst_n clears the decoder state, the sequencer and the output
//   valid; the platform register returns to Windows.
// Stalls: with out_ready low the sequencer holds on the pending event; the
//   input stays closed until the last event of the byte is in the register.
// ----------------------------------------------------------------------------
module utf8_to_unicode_keystrokes import u2k_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_value,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] action,
	output logic [2:0] key_class,
	output logic [7:0] key_value,
	output logic       run_end,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] platform_mode
);

	u2k_cmd_t    cmd;
	u2k_status_t st;

	// The platform register takes a word in any cycle
	assign cfg_ready = 1'b1;

	// Sequencer: decides which event goes out next
	u2k_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// Decoder state, decimal converter and output register
	u2k_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_value (byte_value),
		.last_byte  (last_byte),
		.cfg_valid  (cfg_valid),
		.cfg_data   (platform_mode),
		.out_ready  (out_ready),
		.cmd        (cmd),
		.st         (st),
		.out_valid  (out_valid),
		.action     (action),
		.key_class  (key_class),
		.key_value  (key_value),
		.run_end    (run_end)
	);

endmodule

// ----- rtl/u2k_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2k_datapath: decoder state, binary-to-decimal unit and output register
// Assembles code points, converts them to BCD one bit a cycle and builds
// the key value of each event from the controller's command.
// ----------------------------------------------------------------------------
module u2k_datapath import u2k_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_data,
	input  logic        out_ready,
	input  u2k_cmd_t    cmd,
	output u2k_status_t st,
	output logic        out_valid,
	output action_t     action,
	output class_t      key_class,
	output logic [7:0]  key_value,
	output logic        run_end
);

	mode_t             mode_q;
	logic [7:0]        byte_q;
	logic              last_q;
	logic [CP_W-1:0]   part_q, part_n;
	logic [1:0]        pend_q, pend_n;
	logic              disc_q, disc_n;
	logic [CP_W-1:0]   cp_q, cp_n, bin_q;
	logic [4*BCD_DIGITS-1:0] bcd_q, bcd_adj;
	logic              have_cp;
	res_t              res;
	logic              out_valid_q, end_q;
	action_t           act_q;
	class_t            cls_q;
	logic [7:0]        val_q, val_n;
	logic [31:0]       hex_pad, dec_pad;
	logic [3:0]        hex_nib, dec_nib;
	logic [2:0]        nd_hex, nd_dec, nd;

	// Byte decode
	always_comb begin
		part_n  = part_q;
		pend_n  = pend_q;
		disc_n  = disc_q;
		have_cp = 1'b0;
		cp_n    = '0;
		res     = RES_NONE;
		if (!disc_q) begin
			priority if (pend_q != 2'd0) begin
				part_n = {part_q[CP_W-7:0], byte_q[5:0]};
				pend_n = pend_q - 2'd1;
				if (pend_n == 2'd0) begin
					have_cp = 1'b1;
					cp_n    = part_n;
				end
			end else if (!byte_q[7]) begin
				have_cp = 1'b1;
				cp_n    = {{(CP_W-8){1'b0}}, byte_q};
			end else if (byte_q[7:5] == 3'b110) begin
				part_n = {{(CP_W-5){1'b0}}, byte_q[4:0]};
				pend_n = 2'd1;
			end else if (byte_q[7:4] == 4'b1110) begin
				part_n = {{(CP_W-4){1'b0}}, byte_q[3:0]};
				pend_n = 2'd2;
			end else if (byte_q[7:3] == 5'b11110) begin
				part_n = {{(CP_W-3){1'b0}}, byte_q[2:0]};
				pend_n = 2'd3;
			end else begin
				// bad lead byte decodes as zero
				have_cp = 1'b1;
			end

			if (have_cp) begin
				part_n = '0;
				if (cp_n == '0) begin
					res = RES_REJECT;
				end else if (cp_n < 21'd128) begin
					res = RES_TYPE;
				end else begin
					unique case (mode_q)
						MODE_WIN, MODE_MAC: res = RES_KEYS;
						MODE_LIN: begin
							if ((cp_n >= VS_LO && cp_n <= VS_HI) ||
							    (cp_n >= VSS_LO && cp_n <= VSS_HI))
								res = RES_NONE;
							else
								res = RES_KEYS;
						end
						MODE_UNK: res = RES_REJECT;
					endcase
				end
			end else if (last_q && pend_n != 2'd0) begin
				res = RES_REJECT;
			end

			if (res == RES_REJECT) begin
				disc_n = 1'b1;
				part_n = '0;
				pend_n = 2'd0;
			end
		end
		if (last_q) begin
			part_n = '0;
			pend_n = 2'd0;
			disc_n = 1'b0;
		end
	end

	// Double dabble: add 3 to each digit of five or more, then shift
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	// Digit counts
	always_comb begin
		nd_hex = 3'd1;
		nd_dec = 3'd1;
		for (int i = 1; i < 6; i++)
			if (hex_pad[4*i +: 4] != 4'd0) nd_hex = 3'(i + 1);
		for (int i = 1; i < BCD_DIGITS; i++)
			if (bcd_q[4*i +: 4] != 4'd0) nd_dec = 3'(i + 1);
		if (mode_q == MODE_WIN)
			nd = nd_dec;
		else if (mode_q == MODE_MAC && nd_hex < 3'd4)
			nd = 3'd4;
		else
			nd = nd_hex;
	end

	assign hex_pad = {{(32-CP_W){1'b0}}, cp_q};
	assign dec_pad = {{(32-4*BCD_DIGITS){1'b0}}, bcd_q};
	assign hex_nib = hex_pad[4*cmd.ev_dig +: 4];
	assign dec_nib = dec_pad[4*cmd.ev_dig +: 4];

	always_comb begin
		unique case (cmd.ev_vkind)
			VK_ZERO:  val_n = 8'd0;
			VK_CP:    val_n = cp_q[7:0];
			VK_U:     val_n = KEY_U;
			VK_SPACE: val_n = KEY_SPACE;
			VK_HEX:   val_n = (hex_nib < 4'd10) ? 8'h30 + {4'd0, hex_nib}
			                                    : 8'h37 + {4'd0, hex_nib};
			VK_NUM:   val_n = (dec_nib == 4'd0) ? NUMPAD_ZERO
			                                    : NUMPAD_ONE - 8'd1 + {4'd0, dec_nib};
			VK_NUM0:  val_n = NUMPAD_ZERO;
			default:  val_n = 8'd0;
		endcase
	end

	assign st.res      = res;
	assign st.mode     = mode_q;
	assign st.big      = |cp_q[CP_W-1:8];
	assign st.ndig     = nd;
	assign st.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_WIN;
			part_q      <= '0;
			pend_q      <= 2'd0;
			disc_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				mode_q <= cfg_data;
			if (cmd.decode) begin
				part_q <= part_n;
				pend_q <= pend_n;
				disc_q <= disc_n;
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			byte_q <= byte_value;
			last_q <= last_byte;
		end
		if (cmd.decode) begin
			cp_q  <= cp_n;
			bin_q <= cp_n;
			bcd_q <= '0;
		end else if (cmd.conv_step) begin
			bcd_q <= {bcd_adj[4*BCD_DIGITS-2:0], bin_q[CP_W-1]};
			bin_q <= {bin_q[CP_W-2:0], 1'b0};
		end
		if (cmd.emit) begin
			act_q <= cmd.ev_action;
			cls_q <= cmd.ev_class;
			val_q <= val_n;
			end_q <= cmd.ev_end;
		end
	end

	assign out_valid = out_valid_q;
	assign action    = act_q;
	assign key_class = cls_q;
	assign key_value = val_q;
	assign run_end   = end_q;

endmodule

// ----- rtl/u2k_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2k_ctrl: event sequencer
// Steps through decode, decimal conversion and the prefix, digit and suffix
// events of each host entry method, one event per output slot.
// ----------------------------------------------------------------------------
module u2k_ctrl import u2k_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  u2k_status_t st,
	output u2k_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_ONE  = 3'd2;
	localparam logic [2:0] S_CONV = 3'd3;
	localparam logic [2:0] S_PRE  = 3'd4;
	localparam logic [2:0] S_DIG  = 3'd5;
	localparam logic [2:0] S_POST = 3'd6;

	logic [2:0]       state_q, state_n;
	logic [2:0]       sub_q, sub_n, pre_last;
	logic [2:0]       dig_q, dig_n;
	logic             half_q, half_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             rej_q, rej_n;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd      = '0;
		state_n  = state_q;
		sub_n    = sub_q;
		dig_n    = dig_q;
		half_n   = half_q;
		cnt_n    = cnt_q;
		rej_n    = rej_q;
		pre_last = 3'd0;
		cmd.ev_dig = dig_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_n     = S_DEC;
				end
			end
			S_DEC: begin
				cmd.decode = 1'b1;
				sub_n      = 3'd0;
				unique case (st.res)
					RES_NONE: state_n = S_IDLE;
					RES_REJECT: begin
						rej_n   = 1'b1;
						state_n = S_ONE;
					end
					RES_TYPE: begin
						rej_n   = 1'b0;
						state_n = S_ONE;
					end
					RES_KEYS: begin
						if (st.mode == MODE_WIN) begin
							cnt_n   = CNT_W'(CONV_STEPS);
							state_n = S_CONV;
						end else begin
							state_n = S_PRE;
						end
					end
				endcase
			end
			S_ONE: begin
				cmd.ev_action = rej_q ? ACT_REJECT : ACT_TYPE;
				cmd.ev_class  = CLS_CHAR;
				cmd.ev_vkind  = rej_q ? VK_ZERO : VK_CP;
				cmd.ev_end    = 1'b1;
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_n  = S_IDLE;
				end
			end
			S_CONV: begin
				cmd.conv_step = 1'b1;
				cnt_n         = cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					state_n = S_PRE;
			end
			S_PRE: begin
				cmd.ev_class = CLS_ALT;
				cmd.ev_vkind = VK_ZERO;
				unique case (st.mode)
					MODE_WIN: begin
						pre_last = st.big ? 3'd2 : 3'd0;
						if (sub_q != 3'd0) begin
							cmd.ev_class  = CLS_NUMPAD;
							cmd.ev_vkind  = VK_NUM0;
							cmd.ev_action = (sub_q == 3'd1) ? ACT_PRESS : ACT_RELEASE;
						end
					end
					MODE_LIN: begin
						pre_last = 3'd5;
						unique case (sub_q)
							3'd0: cmd.ev_class = CLS_CTRL;
							3'd1: cmd.ev_class = CLS_SHIFT;
							3'd2: begin
								cmd.ev_class = CLS_CHAR;
								cmd.ev_vkind = VK_U;
							end
							3'd3: begin
								cmd.ev_action = ACT_RELEASE;
								cmd.ev_class  = CLS_CHAR;
								cmd.ev_vkind  = VK_U;
							end
							3'd4: begin
								cmd.ev_action = ACT_RELEASE;
								cmd.ev_class  = CLS_SHIFT;
							end
							default: begin
								cmd.ev_action = ACT_RELEASE;
								cmd.ev_class  = CLS_CTRL;
							end
						endcase
					end
					MODE_MAC, MODE_UNK: pre_last = 3'd0;
				endcase
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (sub_q == pre_last) begin
						dig_n   = st.ndig - 3'd1;
						half_n  = 1'b0;
						state_n = S_DIG;
					end else begin
						sub_n = sub_q + 3'd1;
					end
				end
			end
			S_DIG: begin
				cmd.ev_action = half_q ? ACT_RELEASE : ACT_PRESS;
				cmd.ev_class  = (st.mode == MODE_WIN) ? CLS_NUMPAD : CLS_CHAR;
				cmd.ev_vkind  = (st.mode == MODE_WIN) ? VK_NUM : VK_HEX;
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (!half_q) begin
						half_n = 1'b1;
					end else if (dig_q == 3'd0) begin
						sub_n   = 3'd0;
						state_n = S_POST;
					end else begin
						half_n = 1'b0;
						dig_n  = dig_q - 3'd1;
					end
				end
			end
			S_POST: begin
				if (st.mode == MODE_LIN) begin
					cmd.ev_action = (sub_q == 3'd0) ? ACT_PRESS : ACT_RELEASE;
					cmd.ev_class  = CLS_CHAR;
					cmd.ev_vkind  = VK_SPACE;
					cmd.ev_end    = (sub_q != 3'd0);
				end else begin
					cmd.ev_action = ACT_RELEASE;
					cmd.ev_class  = CLS_ALT;
					cmd.ev_vkind  = VK_ZERO;
					cmd.ev_end    = 1'b1;
				end
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (cmd.ev_end)
						state_n = S_IDLE;
					else
						sub_n = sub_q + 3'd1;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sub_q   <= 3'd0;
			dig_q   <= 3'd0;
			half_q  <= 1'b0;
			cnt_q   <= '0;
			rej_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			sub_q   <= sub_n;
			dig_q   <= dig_n;
			half_q  <= half_n;
			cnt_q   <= cnt_n;
			rej_q   <= rej_n;
		end
	end

endmodule

// ----- rtl/u2k_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2k_checker: port-level checks for the keystroke block
// Watches the output words for well-formed events.
// ----------------------------------------------------------------------------
module u2k_checker import u2k_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] action,
	input logic [2:0] key_class,
	input logic [7:0] key_value,
	input logic       run_end
);

	// Hold a stalled word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) &&
		$stable(key_class) && $stable(key_value) && $stable(run_end))
		else $error("output word changed while stalled");

	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_REJECT |->
		run_end && key_class == CLS_CHAR && key_value == 8'd0)
		else $error("malformed reject word");

	a_type_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_TYPE |->
		run_end && key_class == CLS_CHAR && key_value != 8'd0 && !key_value[7])
		else $error("malformed type word");

	a_numpad_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_class == CLS_NUMPAD |->
		key_value >= NUMPAD_ONE && key_value <= NUMPAD_ZERO &&
		(action == ACT_PRESS || action == ACT_RELEASE))
		else $error("numpad key out of range");

	// Every key series ends on a release
	a_press_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_PRESS |-> !run_end)
		else $error("series ends on a press");

endmodule

bind utf8_to_unicode_keystrokes u2k_checker u_chk (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for utf8_to_unicode_keystrokes
// Feeds UTF-8 text one byte per word and checks every key word against an
// in-bench keystroke predictor. A short directed table goes first: the reset
// method, byte extremes, reject causes and one sample per host method. Random
// texts follow, in phases across all four host methods. Both sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import u2k_pkg::*;

	localparam int SETTLE_CYCLES   = 48;   // converter plus decode, with margin
	localparam int WATCHDOG_LIMIT  = 4000; // cycles with no word moved
	localparam int PHASES          = 8;
	localparam int BYTES_PER_PHASE = 54;
	localparam int PRINT_LIMIT     = 30;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_A    = 8'h41;

	// One key word as it leaves the block
	typedef struct packed {
		action_t    act;
		class_t     cls;
		logic [7:0] val;
		logic       ends_run;
	} key_event_t;

	// How the bench builds the expectation for a byte
	typedef enum logic [1:0] {
		ROW_CFG,     // write the host method, no byte sent
		ROW_PREDICT, // expected words come from the predictor
		ROW_SILENT,  // typed in: the byte gives no word
		ROW_ONE      // typed in: the byte gives exactly the one word listed
	} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		mode_t      host;
		logic [7:0] data;
		logic       fin;
		action_t    act;
		class_t     cls;
		logic [7:0] val;
	} stim_row_t;

	// Directed table. Fields act/cls/val only matter on ROW_ONE rows.
	localparam stim_row_t DIRECTED [28] = '{
		// ASCII right after reset, a letter and the top of the range
		'{ROW_ONE,     MODE_WIN, 8'h41, 1'b1, ACT_TYPE,   CLS_CHAR, 8'h41},
		'{ROW_ONE,     MODE_WIN, 8'h7F, 1'b1, ACT_TYPE,   CLS_CHAR, 8'h7F},
		// zero byte rejects
		'{ROW_ONE,     MODE_WIN, 8'h00, 1'b1, ACT_REJECT, CLS_CHAR, 8'h00},
		// stray continuation byte as lead rejects, rest of text is dropped
		'{ROW_ONE,     MODE_WIN, 8'h80, 1'b0, ACT_REJECT, CLS_CHAR, 8'h00},
		'{ROW_SILENT,  MODE_WIN, 8'h41, 1'b1, ACT_PRESS,  CLS_CHAR, 8'h00},
		// lead bytes above the four-byte range reject
		'{ROW_ONE,     MODE_WIN, 8'hFF, 1'b1, ACT_REJECT, CLS_CHAR, 8'h00},
		'{ROW_ONE,     MODE_WIN, 8'hF8, 1'b1, ACT_REJECT, CLS_CHAR, 8'h00},
		// U+00E9 on Windows: no leading numpad zero
		'{ROW_SILENT,  MODE_WIN, 8'hC3, 1'b0, ACT_PRESS,  CLS_CHAR, 8'h00},
		'{ROW_PREDICT, MODE_WIN, 8'hA9, 1'b1, ACT_PRESS,  CLS_CHAR, 8'h00},
		// overlong encoding of zero rejects
		'{ROW_SILENT,  MODE_WIN, 8'hC0, 1'b0, ACT_PRESS,  CLS_CHAR, 8'h00},
		'{ROW_ONE,     MODE_WIN, 8'h80, 1'b1, ACT_REJECT, CLS_CHAR, 8'h00},
		// text ends inside a three-byte sequence
		'{ROW_SILENT,  MODE_WIN, 8'hE2, 1'b0, ACT_PRESS,  CLS_CHAR, 8'h00},
		'{ROW_ONE,     MODE_WIN, 8'h82, 1'b1, ACT_REJECT, CLS_CHAR, 8'h00},
		// largest 21-bit code point, seven decimal digits
		'{ROW_SILENT,  MODE_WIN, 8'hF7, 1'b0, ACT_PRESS,  CLS_CHAR, 8'h00},
		'{ROW_SILENT,  MODE_WIN, 8'hBF, 1'b0, ACT_PRESS,  CLS_CHAR, 8'h00},
		'{ROW_SILENT,  MODE_WIN, 8'hBF, 1'b0, ACT_PRESS,  CLS_CHAR, 8'h00},
		'{ROW_PREDICT, MODE_WIN, 8'hBF, 1'b1, ACT_PRESS,  CLS_CHAR, 8'h00},
		// Linux: variation selector U+FE0F is swallowed, U+0080 is typed
		'{ROW_CFG,     MODE_LIN, 8'h00, 1'b0, ACT_PRESS,  CLS_CHAR, 8'h00},
		'{ROW_SILENT,  MODE_WIN, 8'hEF, 1'b0, ACT_PRESS,  CLS_CHAR, 8'h00},
		'{ROW_SILENT,  MODE_WIN, 8'hB8, 1'b0, ACT_PRESS,  CLS_CHAR, 8'h00},
		'{ROW_SILENT,  MODE_WIN, 8'h8F, 1'b1, ACT_PRESS,  CLS_CHAR, 8'h00},
		'{ROW_SILENT,  MODE_WIN, 8'hC2, 1'b0, ACT_PRESS,  CLS_CHAR, 8'h00},
		'{ROW_PREDICT, MODE_WIN, 8'h80, 1'b1, ACT_PRESS,  CLS_CHAR, 8'h00},
		// macOS: U+0080 padded to four hex digits
		'{ROW_CFG,     MODE_MAC, 8'h00, 1'b0, ACT_PRESS,  CLS_CHAR, 8'h00},
		'{ROW_SILENT,  MODE_WIN, 8'hC2, 1'b0, ACT_PRESS,  CLS_CHAR, 8'h00},
		'{ROW_PREDICT, MODE_WIN, 8'h80, 1'b1, ACT_PRESS,  CLS_CHAR, 8'h00},
		// unknown method: ASCII still types (non-ASCII rejects, see random part)
		'{ROW_CFG,     MODE_UNK, 8'h00, 1'b0, ACT_PRESS,  CLS_CHAR, 8'h00},
		'{ROW_ONE,     MODE_WIN, 8'h7E, 1'b1, ACT_TYPE,   CLS_CHAR, 8'h7E}
	};

	localparam mode_t HOST_ORDER [4] = '{MODE_WIN, MODE_LIN, MODE_MAC, MODE_UNK};

	// DUT pins
	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] byte_value;
	logic       last_byte;
	logic       out_valid;
	logic       out_ready;
	action_t    action;
	class_t     key_class;
	logic [7:0] key_value;
	logic       run_end;
	logic       cfg_valid;
	logic       cfg_ready;
	mode_t      platform_mode;

	// Sideband that travels with each input word: how to build its expectation
	row_kind_t  row_kind;
	key_event_t row_word;

	// Predictor state, mirrors the decoder
	logic [20:0] cp_acc;
	logic [1:0]  cont_left;
	logic        dropping;
	mode_t       host_mode;

	key_event_t  byte_events[$];   // words caused by the byte being predicted
	key_event_t  pending_keys[$];  // words still owed by the block, oldest first
	logic [7:0]  text_bytes[$];    // random text being assembled

	bit tx_calm;
	int errors;
	int bytes_taken;
	int words_checked;
	int rejects_seen;
	int mode_writes;
	int quiet_cycles;

	utf8_to_unicode_keystrokes u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_value   (byte_value),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.action       (action),
		.key_class    (key_class),
		.key_value    (key_value),
		.run_end      (run_end),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.platform_mode(platform_mode)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Keystroke predictor
	// ------------------------------------------------------------------

	function automatic void key_event(input action_t act, input class_t cls,
			input logic [7:0] val);
		byte_events.push_back('{act, cls, val, 1'b0});
	endfunction

	function automatic void key_tap(input class_t cls, input logic [7:0] val);
		key_event(ACT_PRESS, cls, val);
		key_event(ACT_RELEASE, cls, val);
	endfunction

	function automatic logic [7:0] numpad_usage(input int digit);
		return (digit == 0) ? NUMPAD_ZERO : NUMPAD_ONE + 8'(digit - 1);
	endfunction

	// Uppercase hex, no leading zeros but at least min_digits digits
	function automatic void hex_keys(input logic [20:0] cp, input int min_digits);
		int n;
		int i;
		logic [3:0] d;
		n = 1;
		while (n < 6 && (cp >> (4 * n)) != 0)
			n++;
		if (n < min_digits)
			n = min_digits;
		for (i = n - 1; i >= 0; i--) begin
			d = 4'((cp >> (4 * i)) & 21'hF);
			key_tap(CLS_CHAR, (d < 4'd10) ? CHAR_ZERO + 8'(d) : CHAR_A + 8'(d) - 8'd10);
		end
	endfunction

	// Words for one decoded, nonzero code point; 0 means reject the text
	function automatic bit code_point_keys(input logic [20:0] cp);
		int unsigned v;
		int dec[$];
		bit ok;
		ok = 1'b1;
		if (cp < 21'd128) begin
			key_event(ACT_TYPE, CLS_CHAR, cp[7:0]);
		end else begin
			case (host_mode)
				MODE_WIN: begin
					// Alt held, decimal on the numpad; leading zero picks Unicode above 255
					key_event(ACT_PRESS, CLS_ALT, 8'h00);
					if (cp > 21'd255)
						key_tap(CLS_NUMPAD, NUMPAD_ZERO);
					v = cp;
					while (v != 0) begin
						dec.push_front(int'(v % 10));
						v = v / 10;
					end
					foreach (dec[i])
						key_tap(CLS_NUMPAD, numpad_usage(dec[i]));
					key_event(ACT_RELEASE, CLS_ALT, 8'h00);
				end
				MODE_LIN: begin
					// Variation selectors give nothing at all
					if (!((cp >= VS_LO && cp <= VS_HI) || (cp >= VSS_LO && cp <= VSS_HI))) begin
						key_event(ACT_PRESS, CLS_CTRL, 8'h00);
						key_event(ACT_PRESS, CLS_SHIFT, 8'h00);
						key_tap(CLS_CHAR, KEY_U);
						key_event(ACT_RELEASE, CLS_SHIFT, 8'h00);
						key_event(ACT_RELEASE, CLS_CTRL, 8'h00);
						hex_keys(cp, 1);
						key_tap(CLS_CHAR, KEY_SPACE);
					end
				end
				MODE_MAC: begin
					key_event(ACT_PRESS, CLS_ALT, 8'h00);
					hex_keys(cp, 4);
					key_event(ACT_RELEASE, CLS_ALT, 8'h00);
				end
				default: begin
					ok = 1'b0;
				end
			endcase
		end
		return ok;
	endfunction

	// Drop whatever this byte produced and replace it by a single reject
	function automatic void reject_text();
		byte_events.delete();
		key_event(ACT_REJECT, CLS_CHAR, 8'h00);
		dropping = 1'b1;
		cp_acc = '0;
		cont_left = '0;
	endfunction

	// Advance the predictor by one byte; leaves the byte's words in byte_events
	function automatic void keystrokes_for_byte(input logic [7:0] b, input logic fin);
		logic        have_cp;
		logic [20:0] cp;
		byte_events.delete();
		have_cp = 1'b0;
		cp = '0;
		if (!dropping) begin
			if (cont_left != 0) begin
				// continuation: top two bits are not checked
				cp_acc = {cp_acc[14:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 0) begin
					have_cp = 1'b1;
					cp = cp_acc;
				end
			end else if (!b[7]) begin
				have_cp = 1'b1;
				cp = {13'd0, b};
			end else if (b[7:5] == 3'b110) begin
				cp_acc = {16'd0, b[4:0]};
				cont_left = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				cp_acc = {17'd0, b[3:0]};
				cont_left = 2'd2;
			end else if (b[7:3] == 5'b11110) begin
				cp_acc = {18'd0, b[2:0]};
				cont_left = 2'd3;
			end else begin
				// bad lead byte counts as a decoded zero
				have_cp = 1'b1;
			end

			if (have_cp) begin
				cp_acc = '0;
				if (cp == 0 || !code_point_keys(cp))
					reject_text();
			end else if (fin && cont_left != 0) begin
				reject_text();
			end
		end
		if (fin) begin
			cp_acc = '0;
			cont_left = '0;
			dropping = 1'b0;
		end
		if (byte_events.size() != 0)
			byte_events[byte_events.size() - 1].ends_run = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic check_word();
		key_event_t want;
		words_checked++;
		if (pending_keys.size() == 0) begin
			flag_error($sformatf("unexpected word: action %0d class %0d value %02h end %0d",
				action, key_class, key_value, run_end));
		end else begin
			want = pending_keys.pop_front();
			if (want.act == ACT_REJECT)
				rejects_seen++;
			if (action !== want.act)
				flag_error($sformatf("word %0d: action %0d, expected %0d",
					words_checked, action, want.act));
			if (key_class !== want.cls)
				flag_error($sformatf("word %0d: key_class %0d, expected %0d",
					words_checked, key_class, want.cls));
			if (key_value !== want.val)
				flag_error($sformatf("word %0d: key_value %02h, expected %02h",
					words_checked, key_value, want.val));
			if (run_end !== want.ends_run)
				flag_error($sformatf("word %0d: run_end %0d, expected %0d",
					words_checked, run_end, want.ends_run));
		end
	endtask

	// Sample every handshake at the clock edge, before this edge's updates land
	always @(posedge clk) begin
		if (!arst_n) begin
			cp_acc = '0;
			cont_left = '0;
			dropping = 1'b0;
			host_mode = MODE_WIN;
			pending_keys.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				host_mode = platform_mode;
				mode_writes++;
			end
			if (in_valid && in_ready) begin
				// advance the predictor even when the table supplies the answer
				keystrokes_for_byte(byte_value, last_byte);
				bytes_taken++;
				case (row_kind)
					ROW_ONE:    pending_keys.push_back(row_word);
					ROW_SILENT: ;
					default: begin
						foreach (byte_events[i])
							pending_keys.push_back(byte_events[i]);
					end
				endcase
			end
			if (out_valid && out_ready)
				check_word();
		end
	end

	// Watchdog: end the run if nothing moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d words still expected",
				WATCHDOG_LIMIT, pending_keys.size());
			$display("testbench: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: draw a stall before every word, with calm stretches
	// ------------------------------------------------------------------
	initial begin
		int stall;
		bit calm;
		int draws;
		out_ready = 1'b0;
		calm = 1'b0;
		draws = 0;
		@(posedge clk);
		forever begin
			if (draws % 24 == 0)
				calm = ($urandom_range(0, 3) == 0);
			draws++;
			stall = calm ? 0 : $urandom_range(0, 15);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			// hold ready until one word is taken
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Send one byte word; valid stays high on return so a gapless next word
	// can follow without a dip
	task automatic send_byte(input logic [7:0] b, input logic fin, input row_kind_t kind,
			input key_event_t word);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		byte_value <= b;
		last_byte  <= fin;
		row_kind   <= kind;
		row_word   <= word;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Drop valid, wait for every owed word, then let a silent byte finish
	task automatic let_block_settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_keys.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_host_mode(input mode_t m);
		cfg_valid     <= 1'b1;
		platform_mode <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Continuation byte; now and then with wrong top bits, which the block ignores
	function automatic logic [7:0] cont_byte(input logic [5:0] bits);
		logic [1:0] top;
		top = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'b10;
		return {top, bits};
	endfunction

	// Pick a code point and an encoding length and append its bytes
	function automatic void append_code_point();
		logic [20:0] cp;
		int nb;
		case ($urandom_range(0, 10))
			0, 1, 2: begin cp = 21'($urandom_range(1, 127));          nb = 1; end
			3:       begin cp = 21'($urandom_range(128, 255));        nb = 2; end
			4:       begin cp = 21'($urandom_range(256, 2047));       nb = 2; end
			5, 6:    begin cp = 21'($urandom_range(2048, 65535));     nb = 3; end
			7:       begin cp = 21'($urandom_range(65536, 21'h1FFFFF)); nb = 4; end
			8: begin
				// variation selectors, both blocks
				if ($urandom_range(0, 1) == 0) begin
					cp = VS_LO + 21'($urandom_range(0, 15));
					nb = 3;
				end else begin
					cp = VSS_LO + 21'($urandom_range(0, 16'hEF));
					nb = 4;
				end
			end
			9: begin
				// overlong, zero included
				cp = 21'($urandom_range(0, 127));
				nb = $urandom_range(2, 4);
			end
			default: begin
				// encoding and decimal/hex width boundaries
				case ($urandom_range(0, 7))
					0:       begin cp = 21'h00080;  nb = 2; end
					1:       begin cp = 21'h000FF;  nb = 2; end
					2:       begin cp = 21'h00100;  nb = 2; end
					3:       begin cp = 21'h007FF;  nb = 2; end
					4:       begin cp = 21'h00800;  nb = 3; end
					5:       begin cp = 21'h0FFFF;  nb = 3; end
					6:       begin cp = 21'h10000;  nb = 4; end
					default: begin cp = 21'h1FFFFF; nb = 4; end
				endcase
			end
		endcase
		case (nb)
			1: text_bytes.push_back({1'b0, cp[6:0]});
			2: begin
				text_bytes.push_back({3'b110, cp[10:6]});
				text_bytes.push_back(cont_byte(cp[5:0]));
			end
			3: begin
				text_bytes.push_back({4'b1110, cp[15:12]});
				text_bytes.push_back(cont_byte(cp[11:6]));
				text_bytes.push_back(cont_byte(cp[5:0]));
			end
			default: begin
				text_bytes.push_back({5'b11110, cp[20:18]});
				text_bytes.push_back(cont_byte(cp[17:12]));
				text_bytes.push_back(cont_byte(cp[11:6]));
				text_bytes.push_back(cont_byte(cp[5:0]));
			end
		endcase
	endfunction

	// One random text: mostly well-formed, some noise, some cut short
	task automatic send_text(inout int sent);
		int r;
		int pos;
		int n;
		text_bytes.delete();
		tx_calm = ($urandom_range(0, 4) == 0);
		r = $urandom_range(0, 19);
		if (r == 0) begin
			n = $urandom_range(1, 4);
			repeat (n) text_bytes.push_back(8'($urandom));
		end else begin
			n = $urandom_range(1, 5);
			repeat (n) append_code_point();
			// end the text on a lone lead byte
			if (r == 1)
				text_bytes.push_back(8'($urandom_range(8'hC0, 8'hF7)));
			// drop a raw byte somewhere in the text
			if (r == 2) begin
				pos = $urandom_range(0, text_bytes.size());
				text_bytes.insert(pos, 8'($urandom));
			end
		end
		foreach (text_bytes[i])
			send_byte(text_bytes[i], i == text_bytes.size() - 1, ROW_PREDICT, '0);
		sent += text_bytes.size();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int p;
		int sent;
		mode_t m;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		byte_value    = 8'h00;
		last_byte     = 1'b0;
		cfg_valid     = 1'b0;
		platform_mode = MODE_WIN;
		row_kind      = ROW_PREDICT;
		row_word      = '0;
		tx_calm       = 1'b0;
		errors        = 0;
		bytes_taken   = 0;
		words_checked = 0;
		rejects_seen  = 0;
		mode_writes   = 0;
		quiet_cycles  = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; host method changes only with the block idle
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				let_block_settle();
				write_host_mode(DIRECTED[i].host);
			end else begin
				send_byte(DIRECTED[i].data, DIRECTED[i].fin, DIRECTED[i].kind,
					'{DIRECTED[i].act, DIRECTED[i].cls, DIRECTED[i].val, 1'b1});
			end
		end

		// Random phases: each method once in order, then random methods
		for (p = 0; p < PHASES; p++) begin
			let_block_settle();
			m = (p < 4) ? HOST_ORDER[p] : HOST_ORDER[$urandom_range(0, 3)];
			write_host_mode(m);
			sent = 0;
			while (sent < BYTES_PER_PHASE)
				send_text(sent);
		end

		let_block_settle();

		$display("summary: %0d bytes decoded, %0d key words compared, %0d texts rejected",
			bytes_taken, words_checked, rejects_seen);
		$display("summary: %0d host method writes over all four methods, %0d mismatches",
			mode_writes, errors);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/u2k_pkg.sv
rtl/u2k_datapath.sv
rtl/u2k_ctrl.sv
rtl/utf8_to_unicode_keystrokes.sv
rtl/u2k_checker.sv
verif/testbench.sv
